FILE: rtl/pbt_pkg.sv
`default_nettype none

package pbt_pkg;

  // Default channel count and the fixed extra shift on the incoming sum
  localparam int NumChannelsDef = 2;
  localparam int SumShift       = 1;

  // Field and port widths
  localparam int ChanW    = 1;
  localparam int RawW     = 17;
  localparam int LevelW   = 31;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_TRACK_ENABLE   = 3'd0,
    REG_ALPHA_SHIFT    = 3'd1,
    REG_ALPHA_MULT     = 3'd2,
    REG_QUIET_LIMIT    = 3'd3,
    REG_DRIFT_LEVEL    = 3'd4,
    REG_NEGATIVE_LIMIT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               track_enable;
    logic [2:0]         alpha_shift;
    logic [3:0]         alpha_mult;
    logic [4:0]         quiet_limit;
    logic [14:0]        drift_level;
    logic signed [15:0] negative_limit;
  } cfg_t;

  // Per-channel tracking state
  typedef struct packed {
    logic [31:0] filtered;
    logic [31:0] baseline;
    logic [31:0] peak;
    logic [31:0] cur_level;
    logic [7:0]  quiet_count;
    logic        calib;
  } chan_state_t;

  localparam cfg_t CfgReset = '{
    track_enable:   1'b1,
    alpha_shift:    3'd2,
    alpha_mult:     4'd3,
    quiet_limit:    5'd1,
    drift_level:    15'd10,
    negative_limit: 16'hFFF6
  };

  localparam chan_state_t ChanReset = '{
    filtered:    32'd0,
    baseline:    32'd0,
    peak:        32'd0,
    cur_level:   32'd0,
    quiet_count: 8'd0,
    calib:       1'b1
  };

endpackage

`default_nettype wire

FILE: rtl/pbt_step.sv
`default_nettype none

// One tracking step for one channel: filter update, baseline logic, clamp.
module pbt_step (
  input  wire pbt_pkg::cfg_t        cfg_i,
  input  wire pbt_pkg::chan_state_t st_i,
  input  wire logic signed [pbt_pkg::RawW-1:0] raw_sum_i,
  output pbt_pkg::chan_state_t      st_o
);

  logic signed [31:0]            fv_sh;
  logic [31:0]                   prod;
  logic [3:0]                    sum_amt;
  logic signed [pbt_pkg::RawW-1:0] raw_shr;
  logic [31:0]                   raw_sh;
  logic [31:0]                   filt;
  logic signed [31:0]            neg_ext;
  logic signed [31:0]            drift_ext;
  logic [7:0]                    qlim_x8;
  logic [7:0]                    qc;
  logic [31:0]                   cl;
  logic [31:0]                   bl;
  logic [31:0]                   pk;
  logic                          cal;

  // IIR filter: shifted old value times multiplier plus shifted new sum
  always_comb begin
    fv_sh   = $signed(st_i.filtered) >>> cfg_i.alpha_shift;
    prod    = fv_sh * {28'd0, cfg_i.alpha_mult};
    sum_amt = 4'(pbt_pkg::SumShift) + {1'b0, cfg_i.alpha_shift};
    raw_shr = raw_sum_i >>> sum_amt;
    raw_sh  = {{(32 - pbt_pkg::RawW){raw_shr[pbt_pkg::RawW-1]}}, raw_shr};
    filt    = prod + raw_sh;
  end

  // Baseline, peak and calibration logic
  always_comb begin
    neg_ext   = {{16{cfg_i.negative_limit[15]}}, cfg_i.negative_limit};
    drift_ext = {17'd0, cfg_i.drift_level};
    qlim_x8   = {cfg_i.quiet_limit, 3'b000};
    cl        = st_i.cur_level;
    bl        = st_i.baseline;
    pk        = st_i.peak;
    qc        = st_i.quiet_count;
    cal       = st_i.calib;

    if (cfg_i.track_enable) begin
      cl = filt - st_i.baseline;
      if ($signed(cl) < neg_ext) begin
        // large negative excursion: snap the baseline
        bl = filt;
        qc = 8'd0;
        cl = 32'd0;
      end else if (!st_i.calib) begin
        if ($signed(pk) < $signed(cl)) begin
          pk = cl;
        end
        if (qc < {3'd0, cfg_i.quiet_limit}) begin
          qc = qc + 8'd1;
        end else begin
          qc = 8'd0;
        end
        // end of peak window: re-base when the peak stayed low
        if (qc == 8'd0 && $signed(pk) < drift_ext) begin
          bl = filt + 32'(drift_ext);
          cl = 32'd0;
        end
        if (qc == 8'd0) begin
          pk = 32'd0;
        end
      end else begin
        // calibrating: baseline follows the filter
        bl = filt;
        if (cl[31] || cl == 32'd0) begin
          qc = qc + 8'd1;
        end else begin
          qc = 8'd0;
        end
        if (qc > qlim_x8) begin
          cal = 1'b0;
          qc  = 8'd0;
        end
      end
    end

    // clamp at zero
    if (cl[31]) begin
      cl = 32'd0;
    end

    st_o.filtered    = filt;
    st_o.baseline    = bl;
    st_o.peak        = pk;
    st_o.cur_level   = cl;
    st_o.quiet_count = qc;
    st_o.calib       = cal;
  end

endmodule

`default_nettype wire

FILE: rtl/proximity_baseline_tracker.sv
// Path: an accepted item is held in the input register until the step fires, which
// loads its result into the result register; an output stall holds it back.
// Throughput: one item per cycle unless the output stalls; channel state is read,
// updated and written back with the result, so same-channel items follow directly.
// Reset: asynchronous, clears the pipeline, loads register defaults and sets
// every channel to zero state with calibration active.
`default_nettype none

module proximity_baseline_tracker #(
  parameter int NUM_CHANNELS = pbt_pkg::NumChannelsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pbt_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [pbt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [pbt_pkg::ChanW-1:0]       channel_i,
  input  wire logic signed [pbt_pkg::RawW-1:0] raw_sum_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [pbt_pkg::ChanW-1:0]            channel_out_o,
  output logic [pbt_pkg::LevelW-1:0]           level_o,
  output logic                                 calibrating_o
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  pbt_pkg::cfg_t        cfg_q;
  pbt_pkg::chan_state_t st_q [NUM_CHANNELS];
  pbt_pkg::chan_state_t st_next;

  logic                              in_vld_q;
  logic [pbt_pkg::ChanW-1:0]         in_chan_q;
  logic signed [pbt_pkg::RawW-1:0]   in_raw_q;
  logic                              out_vld_q;
  logic [pbt_pkg::ChanW-1:0]         out_chan_q;
  logic [pbt_pkg::LevelW-1:0]        out_level_q;
  logic                              out_cal_q;
  logic                              fire;
  logic                              in_xfer;
  logic [IdxW-1:0]                   ch_idx;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pbt_pkg::CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pbt_pkg::REG_TRACK_ENABLE:   cfg_q.track_enable   <= cfg_wdata_i[0];
        pbt_pkg::REG_ALPHA_SHIFT:    cfg_q.alpha_shift    <= cfg_wdata_i[2:0];
        pbt_pkg::REG_ALPHA_MULT:     cfg_q.alpha_mult     <= cfg_wdata_i[3:0];
        pbt_pkg::REG_QUIET_LIMIT:    cfg_q.quiet_limit    <= cfg_wdata_i[4:0];
        pbt_pkg::REG_DRIFT_LEVEL:    cfg_q.drift_level    <= cfg_wdata_i[14:0];
        pbt_pkg::REG_NEGATIVE_LIMIT: cfg_q.negative_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the step fires when the result register is free or draining
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Channels beyond the count fold back onto the available state
  assign ch_idx = (NUM_CHANNELS > 1) ? IdxW'(in_chan_q) : '0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_chan_q <= channel_i;
      in_raw_q  <= raw_sum_i;
    end
  end

  pbt_step u_step (
    .cfg_i     (cfg_q),
    .st_i      (st_q[ch_idx]),
    .raw_sum_i (in_raw_q),
    .st_o      (st_next)
  );

  // Per-channel state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        st_q[i] <= pbt_pkg::ChanReset;
      end
    end else if (fire) begin
      st_q[ch_idx] <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_chan_q  <= in_chan_q;
      out_level_q <= st_next.cur_level[pbt_pkg::LevelW-1:0];
      out_cal_q   <= st_next.calib;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign channel_out_o = out_chan_q;
  assign level_o       = out_level_q;
  assign calibrating_o = out_cal_q;

  // Checks
  a_fire_loads_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) fire |=> out_vld_q
  ) else $error("step fired but no result was registered");

  a_empty_input_ready: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !in_vld_q |-> in_ready_o
  ) else $error("empty input register refused a transfer");

  a_untracked_baseline: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fire && !cfg_q.track_enable |=>
      st_q[$past(ch_idx)].baseline == $past(st_q[ch_idx].baseline)
  ) else $error("baseline changed while tracking was disabled");

endmodule

`default_nettype wire
